FILE: hw/rtl/rbm_pkg.sv
// shared types and constants for the range presence bitmap
`default_nettype none

package rbm_pkg;

    localparam int DOMAIN_SIZE_DEF = 1024;
    localparam int WORD_BITS_DEF   = 64;
    localparam int FIELD_W         = 11;
    localparam int CMD_W           = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET  = 2'd0,
        CMD_CLR  = 2'd1,
        CMD_FLIP = 2'd2
    } t_cmd;

    typedef struct packed {
        logic clear_step;
        logic load_item;
        logic modify_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic addr_last;
        logic stop;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: hw/rtl/rbm_dp.sv
// datapath: word memory, range masks, read-modify-write and first-zero search
`default_nettype none

module rbm_dp #(
    parameter int DOMAIN_SIZE = rbm_pkg::DOMAIN_SIZE_DEF,
    parameter int WORD_BITS   = rbm_pkg::WORD_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire rbm_pkg::t_dp_cmd          i_cmd_bus,
    output rbm_pkg::t_dp_sts               o_sts,
    input  wire [rbm_pkg::CMD_W-1:0]       i_cmd,
    input  wire [rbm_pkg::FIELD_W-1:0]     i_range_low,
    input  wire [rbm_pkg::FIELD_W-1:0]     i_range_high,
    output logic [rbm_pkg::FIELD_W-1:0]    o_first_missing,
    output logic                           o_range_error
);

    localparam int NW = (DOMAIN_SIZE + WORD_BITS - 1) / WORD_BITS;
    localparam int AW = (NW > 1) ? $clog2(NW) : 1;
    localparam int PW = $clog2(DOMAIN_SIZE + 2);
    localparam int CW = (PW > rbm_pkg::FIELD_W) ? PW : rbm_pkg::FIELD_W;
    localparam int BW = CW + 1;
    localparam int SW = $clog2(WORD_BITS + 1);
    localparam int WI = $clog2(WORD_BITS);
    localparam logic signed [BW:0] WB_S  = (BW+1)'(WORD_BITS);
    localparam logic signed [BW:0] DOM_S = (BW+1)'(DOMAIN_SIZE);

    logic [WORD_BITS-1:0] r_mem [NW];
    logic [WORD_BITS-1:0] r_rdata;
    logic [AW-1:0]        r_addr, n_addr;
    logic [BW-1:0]        r_base;
    logic [rbm_pkg::CMD_W-1:0] r_cmd;
    logic [CW-1:0]        r_lo_idx, r_hi_idx;
    logic                 r_bad;
    logic                 r_found;
    logic [BW-1:0]        r_first;
    logic [rbm_pkg::FIELD_W-1:0] r_out_first;
    logic                 r_out_err;

    logic                 addr_last;
    logic                 upd;
    logic signed [BW:0]   lo_off, hi_end_off, dom_off;
    logic [WORD_BITS-1:0] rng_mask, dom_mask, new_word, zeros, wdata;
    logic [WI-1:0]        z_idx;
    logic                 found_now, past, we;
    logic [CW-1:0]        lo_ext, hi_ext;
    logic                 in_bad;

    function automatic logic [WORD_BITS-1:0] ge_mask(input logic signed [BW:0] off);
        logic [WORD_BITS-1:0] m;
        m = '1;
        if (off <= 0) begin
            m = '1;
        end else if (off >= WB_S) begin
            m = '0;
        end else begin
            m = m << off[SW-1:0];
        end
        return m;
    endfunction

    assign addr_last = (r_addr == AW'(NW - 1));

    always_comb begin
        lo_ext = CW'(i_range_low);
        hi_ext = CW'(i_range_high);
        in_bad = (i_range_low == '0) || (i_range_low > i_range_high)
                 || (hi_ext > CW'(DOMAIN_SIZE));
    end

    always_comb begin
        upd        = !r_bad && ((r_cmd == rbm_pkg::CMD_SET) || (r_cmd == rbm_pkg::CMD_CLR)
                                || (r_cmd == rbm_pkg::CMD_FLIP));
        lo_off     = $signed({2'b00, r_lo_idx}) - $signed({1'b0, r_base});
        hi_end_off = $signed({2'b00, r_hi_idx}) + (BW+1)'(1) - $signed({1'b0, r_base});
        dom_off    = DOM_S - $signed({1'b0, r_base});
        rng_mask   = upd ? (ge_mask(lo_off) & ~ge_mask(hi_end_off)) : '0;
        dom_mask   = ~ge_mask(dom_off);
        case (r_cmd)
            rbm_pkg::CMD_SET:  new_word = r_rdata | rng_mask;
            rbm_pkg::CMD_CLR:  new_word = r_rdata & ~rng_mask;
            rbm_pkg::CMD_FLIP: new_word = r_rdata ^ rng_mask;
            default:           new_word = r_rdata;
        endcase
        zeros = ~new_word & dom_mask;
        z_idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (zeros[i]) begin
                z_idx = WI'(i);
            end
        end
        found_now = r_found || (zeros != '0);
        past      = !upd || (hi_end_off <= WB_S);
        we        = i_cmd_bus.clear_step || i_cmd_bus.modify_step;
        wdata     = i_cmd_bus.clear_step ? '0 : new_word;
        n_addr    = addr_last ? '0 : r_addr + AW'(1);
    end

    assign o_sts.addr_last = addr_last;
    assign o_sts.stop      = (found_now && past) || addr_last;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_addr] <= wdata;
        end
        r_rdata <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr  <= '0;
            r_base  <= '0;
            r_found <= 1'b0;
        end else if (i_cmd_bus.load_item) begin
            r_addr  <= '0;
            r_base  <= '0;
            r_found <= 1'b0;
        end else if (i_cmd_bus.clear_step) begin
            r_addr <= n_addr;
        end else if (i_cmd_bus.modify_step) begin
            r_addr  <= n_addr;
            r_base  <= r_base + BW'(WORD_BITS);
            r_found <= found_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.load_item) begin
            r_cmd    <= i_cmd;
            r_lo_idx <= lo_ext - CW'(1);
            r_hi_idx <= hi_ext - CW'(1);
            r_bad    <= in_bad;
            r_first  <= BW'(DOMAIN_SIZE + 1);
        end else if (i_cmd_bus.modify_step && !r_found && (zeros != '0)) begin
            r_first <= r_base + BW'(z_idx) + BW'(1);
        end
        if (i_cmd_bus.load_out) begin
            r_out_first <= r_first[rbm_pkg::FIELD_W-1:0];
            r_out_err   <= r_bad;
        end
    end

    assign o_first_missing = r_out_first;
    assign o_range_error   = r_out_err;

endmodule

`default_nettype wire

FILE: hw/rtl/rbm_ctrl.sv
// controller: clearing pass, word walk sequencing and handshakes
`default_nettype none

module rbm_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output rbm_pkg::t_dp_cmd       o_cmd_bus,
    input  wire rbm_pkg::t_dp_sts  i_sts
);

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_READ   = 5'b00100,
        ST_MODIFY = 5'b01000,
        ST_FINISH = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd_bus   = '0;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_CLEAR: begin
                o_cmd_bus.clear_step = 1'b1;
                if (i_sts.addr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd_bus.load_item = 1'b1;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_MODIFY;
            end
            ST_MODIFY: begin
                o_cmd_bus.modify_step = 1'b1;
                n_state = i_sts.stop ? ST_FINISH : ST_READ;
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd_bus.load_out = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: hw/rtl/range_bitmap_set_clear_flip_first_zero.sv
// Presence bitmap over positions 1..DOMAIN_SIZE held in a single-port word memory of
// ceil(DOMAIN_SIZE/WORD_BITS) words. After reset the block clears the memory one word
// a cycle and takes no beat meanwhile. Each input beat sets, clears or inverts an
// inclusive range (an invalid range changes nothing and is flagged as an error); the
// block then walks the words from the first (memory read, then modify, write back and
// search for the lowest absent bit), and stops once an absent bit is found and the range
// is passed, or at the last word. With the read-modify-write over the one memory port,
// the block takes no new beat until the walk ends and its result is loaded, which waits
// for any previous result to leave. The result waits in an output register so a new beat
// is taken while it is pending.
`default_nettype none

module range_bitmap_set_clear_flip_first_zero #(
    parameter int DOMAIN_SIZE = rbm_pkg::DOMAIN_SIZE_DEF,
    parameter int WORD_BITS   = rbm_pkg::WORD_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire [rbm_pkg::CMD_W-1:0]     i_cmd,
    input  wire [rbm_pkg::FIELD_W-1:0]   i_range_low,
    input  wire [rbm_pkg::FIELD_W-1:0]   i_range_high,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [rbm_pkg::FIELD_W-1:0]  o_first_missing,
    output logic                         o_range_error
);

    rbm_pkg::t_dp_cmd cmd_bus;
    rbm_pkg::t_dp_sts sts;

    rbm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd_bus   (cmd_bus),
        .i_sts       (sts)
    );

    rbm_dp #(
        .DOMAIN_SIZE (DOMAIN_SIZE),
        .WORD_BITS   (WORD_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_bus       (cmd_bus),
        .o_sts           (sts),
        .i_cmd           (i_cmd),
        .i_range_low     (i_range_low),
        .i_range_high    (i_range_high),
        .o_first_missing (o_first_missing),
        .o_range_error   (o_range_error)
    );

endmodule

`default_nettype wire
